// ===== src/idl_pkg.sv =====
package idl_pkg;

   // Store geometry and field widths
   localparam int DEPTH      = 4096;
   localparam int SAMPLE_W   = 24;
   localparam int FRAC_W     = 16;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int DELAY_W    = 28;
   localparam int INT_W      = DELAY_W - FRAC_W;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 28;

   // Remainder unit step counter
   localparam int REM_CNT_W = $clog2(INT_W + 1);

   // Lagrange arithmetic widths
   localparam int K_W    = SAMPLE_W + 4;
   localparam int ACC_W  = SAMPLE_W + FRAC_W + 6;
   localparam int LO_W   = ACC_W / 2;
   localparam int HI_W   = ACC_W - LO_W;
   localparam int PHI_W  = HI_W + FRAC_W + 1;
   localparam int PLO_W  = LO_W + FRAC_W;
   localparam int X_W    = ACC_W + 1;
   localparam int U_W    = X_W - FRAC_W - 1;
   localparam int RCP_W  = 32;
   localparam logic [RCP_W-1:0] RECIP3 = 32'h5555_5555;

   // Linear arithmetic width
   localparam int LIN_W = SAMPLE_W + FRAC_W + 2;

   // Saturation input width
   localparam int SAT_W = 48;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 2'd2;

   // Interpolation modes (code 3 runs as Lagrange)
   localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LAGRANGE = 2'd2;

   // Horner step coefficient select
   localparam logic [1:0] HSTEP_K2 = 2'd0;
   localparam logic [1:0] HSTEP_K1 = 2'd1;
   localparam logic [1:0] HSTEP_K0 = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       rd_issue;
      logic       kcoef;
      logic       hmul;
      logic       hadd;
      logic [1:0] hstep;
      logic       lmul;
      logic       lsum;
      logic       div1;
      logic       div2;
      logic       div3;
      logic       div4;
      logic       out_load;
   } idl_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [MODE_W-1:0] mode;
   } idl_status_type;

   // Clamp a wide signed value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = (SAT_W'(1) <<< (SAMPLE_W - 1)) - SAT_W'(1);
      lo = -hi - SAT_W'(1);
      if (v > hi) begin
         return hi[SAMPLE_W-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== src/idl_rem.sv =====
module idl_rem import idl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [INT_W-1:0] dividend,
   input  logic [LEN_W-1:0] divisor,
   output logic             busy,
   output logic [LEN_W-1:0] remainder
);

   logic [REM_CNT_W-1:0] cnt_ff;
   logic [INT_W-1:0]     dvd_ff;
   logic [LEN_W-1:0]     rem_ff;
   logic [LEN_W-1:0]     trial;

   // Shift in the next dividend bit; the remainder stays below the divisor
   assign trial = {rem_ff[LEN_W-2:0], dvd_ff[INT_W-1]};

   // One restoring step per cycle, most significant bit first
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         dvd_ff <= '0;
      end else if (start) begin
         cnt_ff <= REM_CNT_W'(INT_W);
         rem_ff <= '0;
         dvd_ff <= dividend;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - REM_CNT_W'(1);
         rem_ff <= (trial >= divisor) ? trial - divisor : trial;
         dvd_ff <= {dvd_ff[INT_W-2:0], 1'b0};
      end
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

// ===== src/idl_ctrl.sv =====
module idl_ctrl import idl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output idl_cmd_type    cmd,
   input  idl_status_type status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_LAST  = 4'd2;
   localparam logic [3:0] S_KCOEF = 4'd3;
   localparam logic [3:0] S_HMUL  = 4'd4;
   localparam logic [3:0] S_HADD  = 4'd5;
   localparam logic [3:0] S_DIV1  = 4'd6;
   localparam logic [3:0] S_DIV2  = 4'd7;
   localparam logic [3:0] S_DIV3  = 4'd8;
   localparam logic [3:0] S_DIV4  = 4'd9;
   localparam logic [3:0] S_LMUL  = 4'd10;
   localparam logic [3:0] S_LSUM  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !status.busy;

   // Sequence one word through reads, arithmetic and the output slot
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
               case (status.mode)
                  MODE_NEAREST: cnt_in = 2'd0;
                  MODE_LINEAR:  cnt_in = 2'd1;
                  default:      cnt_in = 2'd3;
               endcase
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            if (cnt_ff == 2'd0) begin
               state_in = S_LAST;
            end else begin
               cnt_in = cnt_ff - 2'd1;
            end
         end
         S_LAST: begin
            case (status.mode)
               MODE_NEAREST: state_in = S_OUT;
               MODE_LINEAR:  state_in = S_LMUL;
               default:      state_in = S_KCOEF;
            endcase
         end
         S_KCOEF: begin
            cmd.kcoef = 1'b1;
            cnt_in    = 2'd0;
            state_in  = S_HMUL;
         end
         S_HMUL: begin
            cmd.hmul = 1'b1;
            state_in = S_HADD;
         end
         S_HADD: begin
            cmd.hadd  = 1'b1;
            cmd.hstep = cnt_ff;
            if (cnt_ff == HSTEP_K0) begin
               state_in = S_DIV1;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_HMUL;
            end
         end
         S_DIV1: begin
            cmd.div1 = 1'b1;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            cmd.div2 = 1'b1;
            state_in = S_DIV3;
         end
         S_DIV3: begin
            cmd.div3 = 1'b1;
            state_in = S_DIV4;
         end
         S_DIV4: begin
            cmd.div4 = 1'b1;
            state_in = S_OUT;
         end
         S_LMUL: begin
            cmd.lmul = 1'b1;
            state_in = S_LSUM;
         end
         S_LSUM: begin
            cmd.lsum = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result word until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/idl_datapath.sv =====
module idl_datapath import idl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   input  idl_cmd_type                cmd,
   output idl_status_type             status
);

   // Configuration
   logic [LEN_W-1:0]   len_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic               start_ff;
   logic [LEN_W-1:0]   len_wr;
   logic [LEN_W-1:0]   len_clamped;
   logic               len_write;

   // Line state
   logic [ADDR_W-1:0]  wp_ff;
   logic [LEN_W-1:0]   fill_ff;
   logic [LEN_W-1:0]   wp_ext;
   logic [LEN_W-1:0]   wp_next;
   logic               rem_busy;
   logic [LEN_W-1:0]   base;
   logic [LEN_W-1:0]   base_inc;
   logic [LEN_W-1:0]   rbase;
   logic [LEN_W-1:0]   a_idx;
   logic [LEN_W-1:0]   n_idx;
   logic [LEN_W-1:0]   r_idx;
   logic [LEN_W-1:0]   len_m1;
   logic [FRAC_W-1:0]  fr;

   // Store and tap capture
   logic [SAMPLE_W-1:0]        mem [DEPTH];
   logic [ADDR_W-1:0]          addr_ff;
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       rd_ok_ff;
   logic                       cap_ff;
   logic [SAMPLE_W-1:0]        sample_ff;
   logic signed [SAMPLE_W-1:0] tap0_ff, tap1_ff, tap2_ff, tap3_ff;
   logic signed [SAMPLE_W-1:0] tap_word;

   // Lagrange datapath
   logic signed [K_W-1:0]   n_k, a_k, b_k, c_k;
   logic signed [K_W-1:0]   k3_w, k2_w, k1_w, k0_w;
   logic signed [K_W-1:0]   k2_ff, k1_ff, k0_ff;
   logic signed [K_W-1:0]   ksel;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [HI_W-1:0]  acc_hi;
   logic [LO_W-1:0]         acc_lo;
   logic signed [FRAC_W:0]  fr_s;
   logic signed [PHI_W-1:0] phi_ff;
   logic [PLO_W-1:0]        plo_ff;
   logic [X_W-1:0]          x_w;
   logic [U_W-1:0]          u_ff;
   logic [U_W+RCP_W-1:0]    prod_ff;
   logic [U_W-1:0]          q0;
   logic [U_W-1:0]          r_w;
   logic [U_W-1:0]          q_ff;
   logic signed [U_W:0]     yq;

   // Linear datapath
   logic signed [SAMPLE_W:0]       diff;
   logic signed [LIN_W-1:0]        lin_ff;
   logic signed [LIN_W-1:0]        lin_sum;
   logic signed [LIN_W-FRAC_W-1:0] lin_y;

   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   localparam logic [X_W-1:0] DIV_OFS = (X_W'(3) << FRAC_W) + (X_W'(3) << (ACC_W - 2));
   localparam logic signed [U_W:0] QOFS = (U_W + 1)'(1) <<< (ACC_W - FRAC_W - 3);

   // Clamp a written length into 1..DEPTH
   assign len_wr      = csr_write_data[LEN_W-1:0];
   assign len_clamped = (len_wr == '0) ? LEN_W'(1) :
                        (len_wr > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len_wr;
   assign len_write   = csr_write_enable && (csr_index == CSR_LINE_LENGTH);

   // Take register writes; length and delay writes restart the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_W'(DEPTH);
         delay_ff <= '0;
         mode_ff  <= MODE_NEAREST;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_LINE_LENGTH: begin
                  len_ff   <= len_clamped;
                  start_ff <= 1'b1;
               end
               CSR_DELAY: begin
                  delay_ff <= csr_write_data[DELAY_W-1:0];
                  start_ff <= 1'b1;
               end
               CSR_MODE: begin
                  mode_ff <= csr_write_data[MODE_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Integer delay modulo the length
   idl_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (delay_ff[DELAY_W-1:FRAC_W]),
      .divisor   (len_ff),
      .busy      (rem_busy),
      .remainder (base)
   );

   assign status.busy = start_ff || rem_busy || csr_write_enable;
   assign status.mode = mode_ff;

   // Tap addresses, each wrapped into 0..L-1
   assign fr       = delay_ff[FRAC_W-1:0];
   assign wp_ext   = {1'b0, wp_ff};
   assign len_m1   = len_ff - LEN_W'(1);
   assign base_inc = (base == len_m1) ? '0 : base + LEN_W'(1);
   assign rbase    = fr[FRAC_W-1] ? base_inc : base;
   assign a_idx    = (wp_ext >= base) ? wp_ext - base : wp_ext + len_ff - base;
   assign r_idx    = (wp_ext >= rbase) ? wp_ext - rbase : wp_ext + len_ff - rbase;
   assign n_idx    = (a_idx == len_m1) ? '0 : a_idx + LEN_W'(1);
   assign wp_next  = (wp_ext == len_m1) ? '0 : wp_ext + LEN_W'(1);

   // Advance the write pointer and fill count; a length write clears both
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (len_write) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.out_load) begin
         wp_ff <= wp_next[ADDR_W-1:0];
         if (fill_ff < len_ff) begin
            fill_ff <= fill_ff + LEN_W'(1);
         end
      end
   end

   // Load the first tap address, then step down one slot per read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_in_sample;
         case (mode_ff)
            MODE_NEAREST: addr_ff <= r_idx[ADDR_W-1:0];
            MODE_LINEAR:  addr_ff <= a_idx[ADDR_W-1:0];
            default:      addr_ff <= n_idx[ADDR_W-1:0];
         endcase
      end else if (cmd.rd_issue) begin
         addr_ff <= (addr_ff == '0) ? len_m1[ADDR_W-1:0] : addr_ff - ADDR_W'(1);
      end
   end

   // Sample store: registered read, write of the new word at the pointer
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mem[wp_ff] <= sample_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[addr_ff];
         rd_ok_ff   <= ({1'b0, addr_ff} < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
      end else begin
         cap_ff <= cmd.rd_issue;
      end
   end

   // Shift captured taps; a slot not yet written since the clear reads zero
   assign tap_word = rd_ok_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cap_ff) begin
         tap0_ff <= tap_word;
         tap1_ff <= tap0_ff;
         tap2_ff <= tap1_ff;
         tap3_ff <= tap2_ff;
      end
   end

   // Six times the cubic through n, a, b, c
   assign n_k  = tap3_ff;
   assign a_k  = tap2_ff;
   assign b_k  = tap1_ff;
   assign c_k  = tap0_ff;
   assign k3_w = c_k - n_k + (a_k <<< 1) + a_k - (b_k <<< 1) - b_k;
   assign k2_w = (n_k <<< 1) + n_k - (a_k <<< 2) - (a_k <<< 1) + (b_k <<< 1) + b_k;
   assign k1_w = (b_k <<< 2) + (b_k <<< 1) - (n_k <<< 1) - (a_k <<< 1) - a_k - c_k;
   assign k0_w = (a_k <<< 2) + (a_k <<< 1);

   always_comb begin
      case (cmd.hstep)
         HSTEP_K2: ksel = k2_ff;
         HSTEP_K1: ksel = k1_ff;
         default:  ksel = k0_ff;
      endcase
   end

   // Split the accumulator so each product stays narrow
   assign acc_hi = acc_ff[ACC_W-1:LO_W];
   assign acc_lo = acc_ff[LO_W-1:0];
   assign fr_s   = $signed({1'b0, fr});

   // Horner evaluation: multiply stage, then add stage
   always_ff @(posedge clock) begin
      if (cmd.kcoef) begin
         k2_ff  <= k2_w;
         k1_ff  <= k1_w;
         k0_ff  <= k0_w;
         acc_ff <= ACC_W'(k3_w) <<< FRAC_W;
      end else if (cmd.hadd) begin
         acc_ff <= (ACC_W'(ksel) <<< FRAC_W)
                 + (ACC_W'(phi_ff) <<< (LO_W - FRAC_W))
                 + ACC_W'($signed({1'b0, plo_ff[PLO_W-1:FRAC_W]}));
      end
      if (cmd.hmul) begin
         phi_ff <= acc_hi * fr_s;
         plo_ff <= acc_lo * fr;
      end
   end

   // Round and divide by six times one: offset, shift, reciprocal of three
   assign x_w = X_W'(acc_ff) + DIV_OFS;
   assign q0  = prod_ff[U_W+RCP_W-1:RCP_W];
   assign r_w = u_ff - ((q0 << 1) + q0);
   assign yq  = $signed({1'b0, q_ff}) - QOFS;

   always_ff @(posedge clock) begin
      if (cmd.div1) begin
         u_ff <= x_w[X_W-1:FRAC_W+1];
      end
      if (cmd.div2) begin
         prod_ff <= u_ff * RECIP3;
      end
      if (cmd.div3) begin
         q_ff <= (r_w >= U_W'(3)) ? q0 + U_W'(1) : q0;
      end
   end

   // Linear: a plus fraction times the step to b, rounded half up
   assign diff    = tap0_ff - tap1_ff;
   assign lin_sum = $signed({tap1_ff, 1'b1, {(FRAC_W - 1){1'b0}}}) + lin_ff;
   assign lin_y   = lin_sum[LIN_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (cmd.lmul) begin
         lin_ff <= diff * fr_s;
      end
      if (cmd.lsum) begin
         y_ff <= sat_sample(SAT_W'(lin_y));
      end else if (cmd.div4) begin
         y_ff <= sat_sample(SAT_W'(yq));
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= (mode_ff == MODE_NEAREST) ? tap0_ff : y_ff;
      end
   end

   assign rsp_out_sample = rsp_data_ff;

endmodule

// ===== src/interpolated_delay_line.sv =====
// A word runs through the tap reads, the linear or Lagrange arithmetic if the mode needs it and
// the output state, which waits for a free result slot; no new word is taken before then. Taps
// are read one per cycle via the single store read port; Horner steps share one multiply and add
// stage. A length or delay write holds req_ready low until the delay is reduced mod L.
// Reset is synchronous: control, pointer and fill count clear at once; unwritten
// store slots read as zero through the fill count, so no clearing pass runs.
module interpolated_delay_line import idl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   idl_cmd_type    cmd;
   idl_status_type status;

   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   idl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_in_sample    (req_in_sample),
      .rsp_out_sample   (rsp_out_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== src/idl_checker.sv =====
module idl_checker import idl_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input logic                       csr_write_enable
);

   logic [1:0] pend_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Track words accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else if (req_fire && !rsp_fire) begin
         pend_ff <= pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_ff <= pend_ff - 2'd1;
      end
   end

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample))
      else $error("result word changed while stalled");

   // No word is taken in a cycle with a register write
   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !req_ready)
      else $error("input accepted during register write");

   // One word in the arithmetic at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("input ready right after an accept");

   // Every result traces back to an accepted word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an accepted input");

endmodule

bind interpolated_delay_line idl_checker u_checker (.*);

// ===== test/interpolated_delay_line_checker.sv =====
`timescale 1ns / 100ps

module interpolated_delay_line_checker import idl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   output int                         failures,
   output int                         outstanding
);

   localparam longint ONE   = longint'(1) << FRAC_W;
   localparam longint S_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint S_MIN = -S_MAX - 1;

   // Shadow copy of the line state and registers
   logic signed [SAMPLE_W-1:0] line_store [0:DEPTH-1];
   longint                     wr_ptr;
   longint                     line_len;
   longint                     line_delay;
   logic [MODE_W-1:0]          line_mode;

   // Samples still owed by the block, oldest first
   logic signed [SAMPLE_W-1:0] owed_samples [$];

   function automatic void clear_line();
      for (int i = 0; i < DEPTH; i++) begin
         line_store[i] = '0;
      end
      wr_ptr = 0;
   endfunction

   // Store entry back slots behind the write pointer, moved forward by off
   function automatic longint line_tap(input longint back, input longint off);
      longint idx;
      idx = (wr_ptr + line_len - (back % line_len) + off) % line_len;
      return longint'(line_store[int'(idx)]);
   endfunction

   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      q = num / den;
      if (num < 0 && q * den != num) begin
         q = q - 1;
      end
      return q;
   endfunction

   // Interpolated read at the current delay, before the new word is stored
   function automatic logic signed [SAMPLE_W-1:0] delayed_output();
      longint whole;
      longint frac;
      longint a;
      longint b;
      longint n;
      longint c;
      longint acc;
      longint y;
      whole = line_delay >> FRAC_W;
      frac  = line_delay % ONE;
      case (line_mode)
         MODE_NEAREST: begin
            y = line_tap((line_delay + (ONE >> 1)) >> FRAC_W, 0);
         end
         MODE_LINEAR: begin
            a   = line_tap(whole, 0);
            b   = line_tap(whole + 1, 0);
            acc = a * ONE + frac * (b - a);
            y   = (acc + (ONE >> 1)) >>> FRAC_W;
         end
         default: begin
            n   = line_tap(whole, 1);
            a   = line_tap(whole, 0);
            b   = line_tap(whole + 1, 0);
            c   = line_tap(whole + 2, 0);
            // Horner on six times the cubic, floor after each fraction multiply
            acc = (-n + 3 * a - 3 * b + c) * ONE;
            acc = (3 * n - 6 * a + 3 * b) * ONE + ((acc * frac) >>> FRAC_W);
            acc = (-2 * n - 3 * a + 6 * b - c) * ONE + ((acc * frac) >>> FRAC_W);
            acc = (6 * a) * ONE + ((acc * frac) >>> FRAC_W);
            y   = floor_quot(acc + 3 * ONE, 6 * ONE);
         end
      endcase
      if (y > S_MAX) begin
         y = S_MAX;
      end else if (y < S_MIN) begin
         y = S_MIN;
      end
      return SAMPLE_W'(y);
   endfunction

   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      longint                     len_field;
      if (reset) begin
         line_len   = DEPTH;
         line_delay = 0;
         line_mode  = MODE_NEAREST;
         clear_line();
         owed_samples.delete();
      end else begin
         // Track register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LINE_LENGTH: begin
                  len_field = longint'(csr_write_data[LEN_W-1:0]);
                  line_len  = (len_field == 0) ? 1 : ((len_field > DEPTH) ? DEPTH : len_field);
                  clear_line();
               end
               CSR_DELAY: begin
                  line_delay = longint'(csr_write_data[DELAY_W-1:0]);
               end
               CSR_MODE: begin
                  line_mode = csr_write_data[MODE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // Predict the read, then store the new word and advance
         if (req_valid && req_ready) begin
            owed_samples.push_back(delayed_output());
            line_store[int'(wr_ptr)] = req_in_sample;
            wr_ptr = (wr_ptr + 1) % line_len;
         end
         // Compare each delivered word with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (owed_samples.size() == 0) begin
               $error("out_sample: expected none, actual %0d", rsp_out_sample);
               failures = failures + 1;
            end else begin
               want = owed_samples.pop_front();
               if (rsp_out_sample !== want) begin
                  $error("out_sample: expected %0d, actual %0d", want, rsp_out_sample);
                  failures = failures + 1;
               end
            end
         end
      end
      outstanding = owed_samples.size();
   end

endmodule

// ===== test/interpolated_delay_line_test.sv =====
`timescale 1ns / 100ps

module interpolated_delay_line_test;
   import idl_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_WORDS  = 500;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;
   localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_in_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   int failures;
   int outstanding;
   int cycle_count = 0;
   int burst_left = 0;
   int ready_run = 0;
   int stall_run = 0;

   interpolated_delay_line dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_sample    (req_in_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample   (rsp_out_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   interpolated_delay_line_checker out_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_sample    (req_in_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample   (rsp_out_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("interpolated_delay_line_test: errors");
         $finish;
      end
   end

   // Receiver: alternate ready runs and stalls, some runs long and stall free
   always @(negedge clock) begin
      if (stall_run > 0) begin
         rsp_ready <= 1'b0;
         stall_run <= stall_run - 1;
      end else if (ready_run > 0) begin
         rsp_ready <= 1'b1;
         ready_run <= ready_run - 1;
      end else begin
         rsp_ready <= 1'b1;
         ready_run <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         stall_run <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
   end

   // Offer one word, opening a new burst after a random gap when due
   task automatic send_word(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid     <= 1'b1;
      req_in_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every word is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_line(input logic [CSR_DATA_W-1:0] len_data,
                           input logic [CSR_DATA_W-1:0] delay_data,
                           input logic [MODE_W-1:0] mode);
      settle();
      write_reg(CSR_LINE_LENGTH, len_data);
      write_reg(CSR_DELAY, delay_data);
      write_reg(CSR_MODE, CSR_DATA_W'(mode));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return {{(SAMPLE_W - 5){r[4]}}, r[4:0]};
         default: return r[SAMPLE_W-1:0];
      endcase
   endfunction

   initial begin
      int                    sent;
      int                    count;
      int                    cur_len;
      int                    whole;
      logic [CSR_DATA_W-1:0] len_data;
      logic [CSR_DATA_W-1:0] delay_data;
      logic [FRAC_W-1:0]     frac;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: delay zero reads the oldest, still empty slot
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);

      // Short line, linear at one and a half samples
      set_line(CSR_DATA_W'(4), 28'h001_8000, MODE_LINEAR);
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);

      // Lagrange on alternating extremes overshoots and saturates
      settle();
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_LAGRANGE));
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);
      send_word(SAMPLE_MAX);
      send_word(SAMPLE_MIN);

      // Spare mode code with the largest delay, which wraps around the line
      settle();
      write_reg(CSR_DELAY, 28'hFFF_FFFF);
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_SPARE));
      send_word(24'sd1);
      send_word(-24'sd1);
      send_word(24'sd0);

      // Zero length acts as one; nearest rounds just under half down
      set_line(CSR_DATA_W'(0), 28'h000_7FFF, MODE_NEAREST);
      send_word(24'sd5);
      send_word(24'sd6);

      // Line of three: taps alias
      set_line(CSR_DATA_W'(3), 28'h002_4000, MODE_LAGRANGE);
      send_word(24'sd100);
      send_word(-24'sd200);
      send_word(24'sd300);

      // Oversized length with junk upper bits clamps to the full store
      set_line(28'hFFF_FFFF, 28'h001_0000, MODE_LINEAR);
      send_word(SAMPLE_MIN);
      send_word(SAMPLE_MAX);

      // Write to the unused index must change nothing
      set_line(CSR_DATA_W'(2), 28'h000_0000, MODE_NEAREST);
      write_reg(CSR_SPARE, 28'hFFF_FFFF);
      send_word(24'sd7);
      send_word(24'sd8);
      send_word(24'sd9);
      cur_len = 2;

      // Random phases: mostly short lines with delays that reach written words
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         settle();
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 7))
               0:       len_data = CSR_DATA_W'($urandom);
               1:       len_data = CSR_DATA_W'(DEPTH);
               default: len_data = CSR_DATA_W'($urandom_range(1, 40));
            endcase
            write_reg(CSR_LINE_LENGTH, len_data);
            cur_len = int'(len_data[LEN_W-1:0]);
            if (cur_len == 0) begin
               cur_len = 1;
            end else if (cur_len > DEPTH) begin
               cur_len = DEPTH;
            end
         end
         whole = (cur_len > 64) ? $urandom_range(0, 48) : $urandom_range(0, 2 * cur_len + 3);
         case ($urandom_range(0, 5))
            0:       frac = '0;
            1:       frac = 16'h8000;
            2:       frac = 16'h7FFF;
            default: frac = FRAC_W'($urandom);
         endcase
         delay_data = (CSR_DATA_W'(whole) << FRAC_W) | CSR_DATA_W'(frac);
         if ($urandom_range(0, 7) == 0) begin
            delay_data = CSR_DATA_W'($urandom);
         end
         write_reg(CSR_DELAY, delay_data);
         if ($urandom_range(0, 2) != 0) begin
            write_reg(CSR_MODE, CSR_DATA_W'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 9) == 0) begin
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
         end
         count = $urandom_range(8, 40);
         repeat (count) send_word(random_sample());
         sent = sent + count;
      end

      // Drain and give the verdict
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("interpolated_delay_line_test: clean");
      end else begin
         $display("interpolated_delay_line_test: errors");
      end
      $finish;
   end

endmodule
